/* hw/rtl/grid_segment_line_rasterizer_unit_assert.svh */
// Assertion macros shared by the rasterizer RTL.
`ifndef GRID_SEGMENT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define GRID_SEGMENT_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define GSLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gslr: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define GSLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gslr: next-cycle check failed");

`endif

/* hw/rtl/gslr_pkg.sv */
package gslr_pkg;

    // Register file layout
    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = 4;
    localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SCALE        = 2'd2;

    localparam int GRID_W  = 9;
    localparam int SCALE_W = 6;
    localparam int PT_W    = 8;
    localparam int PROD_W  = GRID_W + SCALE_W;
    localparam int PIX_W   = 10;
    localparam int COLOR_W = 32;

    localparam logic [GRID_W-1:0]  RST_GRID_COLUMNS = 9'd10;
    localparam logic [GRID_W-1:0]  RST_GRID_ROWS    = 9'd10;
    localparam logic [SCALE_W-1:0] RST_SCALE        = 6'd30;

    localparam logic [COLOR_W-1:0] COLOR_XMAJOR = 32'hFF00_00FF;
    localparam logic [COLOR_W-1:0] COLOR_YMAJOR = 32'h00AA_AAFF;

    // Signed screen coordinates and decision term
    localparam int COORD_W = 20;
    localparam int K_W     = 24;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [K_W-1:0]     t_k;

    typedef struct packed {
        logic [GRID_W-1:0]  grid_columns;
        logic [GRID_W-1:0]  grid_rows;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_SETK,
        ST_RUN
    } t_state;

    // Steps of the shared multiplier during setup
    typedef enum logic [2:0] {
        PH_COLS,
        PH_ROWS,
        PH_SC,
        PH_SR,
        PH_EC,
        PH_ER,
        PH_DRAIN
    } t_phase;

endpackage

/* hw/rtl/gslr_cfg.sv */
module gslr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gslr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output gslr_pkg::t_cfg                o_cfg
);

    gslr_pkg::t_cfg                  r_cfg;
    logic                            s_wr;
    logic [gslr_pkg::REG_IDX_W-1:0]  s_idx;

    assign pready = 1'b1;
    assign s_wr   = psel & penable & pwrite;
    assign s_idx  = paddr[gslr_pkg::PADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // Write registers, masked to their widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_columns <= gslr_pkg::RST_GRID_COLUMNS;
            r_cfg.grid_rows    <= gslr_pkg::RST_GRID_ROWS;
            r_cfg.scale        <= gslr_pkg::RST_SCALE;
        end else if (s_wr) begin
            unique case (s_idx)
                gslr_pkg::REG_GRID_COLUMNS: r_cfg.grid_columns <= pwdata[gslr_pkg::GRID_W-1:0];
                gslr_pkg::REG_GRID_ROWS:    r_cfg.grid_rows    <= pwdata[gslr_pkg::GRID_W-1:0];
                gslr_pkg::REG_SCALE:        r_cfg.scale        <= pwdata[gslr_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (s_idx)
            gslr_pkg::REG_GRID_COLUMNS: prdata = 32'(r_cfg.grid_columns);
            gslr_pkg::REG_GRID_ROWS:    prdata = 32'(r_cfg.grid_rows);
            gslr_pkg::REG_SCALE:        prdata = 32'(r_cfg.scale);
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

/* hw/rtl/grid_segment_line_rasterizer_unit.sv */
// Setup: after the input word is accepted, one shared 9x6 multiplier runs the steps COLS, ROWS, SC, SR,
// EC, ER and DRAIN, then PREP and SETK, then the first step loads the first word into the output register.
// Throughput: one pixel word per cycle while the output side takes them; an item yields
// N words (N = min(run length, MAX_STEPS), or 1 for an empty run).
// Input ready is high only while the sequencer is idle.
// Reset (i_rst_n low, synchronous) idles the sequencer, drops the output word, loads 10/10/30.
`include "grid_segment_line_rasterizer_unit_assert.svh"

module grid_segment_line_rasterizer_unit #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int MAX_STEPS     = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gslr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // segment in
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [gslr_pkg::PT_W-1:0]     i_start_col,
    input  logic [gslr_pkg::PT_W-1:0]     i_start_row,
    input  logic [gslr_pkg::PT_W-1:0]     i_end_col,
    input  logic [gslr_pkg::PT_W-1:0]     i_end_row,
    // pixel out
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gslr_pkg::PIX_W-1:0]    o_pixel_x,
    output logic [gslr_pkg::PIX_W-1:0]    o_pixel_y,
    output logic [gslr_pkg::COLOR_W-1:0]  o_pixel_color,
    output logic                          o_visible,
    output logic                          o_cut_short,
    output logic                          o_last
);

    localparam int CNT_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_STEPS - 1);
    localparam gslr_pkg::t_coord SW_C = gslr_pkg::t_coord'(SCREEN_WIDTH);
    localparam gslr_pkg::t_coord SH_C = gslr_pkg::t_coord'(SCREEN_HEIGHT);

    gslr_pkg::t_cfg    s_cfg;
    gslr_pkg::t_state  r_state, n_state;
    gslr_pkg::t_phase  r_phase, n_phase;

    // latched segment
    logic                          r_ymaj;
    logic [gslr_pkg::PT_W-1:0]     r_sc, r_sr, r_ec, r_er;

    // shared multiplier and adder
    logic [gslr_pkg::GRID_W-1:0]   s_opa;
    logic [gslr_pkg::PROD_W-1:0]   s_mul, r_prod;
    gslr_pkg::t_coord              s_prod_ext, s_diff, s_half, s_off, s_sum;

    // setup results
    gslr_pkg::t_coord              r_offx, r_offy, r_x, r_y, r_ex, r_ey;
    gslr_pkg::t_coord              r_maj, r_mnr, r_endmaj, r_dmaj, r_dmnr;
    gslr_pkg::t_k                  r_k, r_kpos, r_kneg;
    logic [CNT_W-1:0]              r_count;

    // stepper
    logic                          s_kneg_sel, s_empty, s_more, s_cut, s_lastw, s_vis;
    gslr_pkg::t_k                  s_knext;
    gslr_pkg::t_coord              s_mnr_next, s_px, s_py;

    // control
    logic                          s_accept, s_out_free, s_emit, s_done;

    // output word
    logic                          r_ovalid;
    logic [gslr_pkg::PIX_W-1:0]    r_px, r_py;
    logic [gslr_pkg::COLOR_W-1:0]  r_color;
    logic                          r_vis, r_cut, r_last;

    gslr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // Pick the multiplier operand for this setup step
    always_comb begin
        case (r_phase)
            gslr_pkg::PH_COLS: s_opa = s_cfg.grid_columns;
            gslr_pkg::PH_ROWS: s_opa = s_cfg.grid_rows;
            gslr_pkg::PH_SC:   s_opa = {1'b0, r_sc};
            gslr_pkg::PH_SR:   s_opa = {1'b0, r_sr};
            gslr_pkg::PH_EC:   s_opa = {1'b0, r_ec};
            gslr_pkg::PH_ER:   s_opa = {1'b0, r_er};
            default:           s_opa = '0;
        endcase
    end

    assign s_mul      = s_opa * s_cfg.scale;
    assign s_prod_ext = gslr_pkg::t_coord'(r_prod);

    // Consume the previous product: centring offset or scaled coordinate
    always_comb begin
        case (r_phase) inside
            gslr_pkg::PH_ROWS:               s_diff = SW_C - s_prod_ext;
            default:                         s_diff = SH_C - s_prod_ext;
        endcase
        case (r_phase) inside
            gslr_pkg::PH_SR, gslr_pkg::PH_ER: s_off = r_offx;
            default:                          s_off = r_offy;
        endcase
    end

    // Halve toward zero
    assign s_half = (s_diff + gslr_pkg::t_coord'(s_diff[gslr_pkg::COORD_W-1])) >>> 1;
    assign s_sum  = s_prod_ext + s_off;

    // Step the decision term and the minor axis
    assign s_kneg_sel = r_k[gslr_pkg::K_W-1];
    assign s_knext    = r_k + (s_kneg_sel ? r_kneg : r_kpos);
    assign s_mnr_next = r_mnr + gslr_pkg::t_coord'(!s_kneg_sel);
    assign s_px       = r_ymaj ? s_mnr_next : r_maj;
    assign s_py       = r_ymaj ? r_maj : s_mnr_next;
    assign s_empty    = r_maj > r_endmaj;
    assign s_more     = r_maj < r_endmaj;
    assign s_cut      = s_more && (r_count == CNT_LAST);
    assign s_lastw    = !s_more || s_cut;
    assign s_vis      = (s_px > 0) && (s_py > 0) && (s_px < SW_C) && (s_py < SH_C);

    // Sequencer outputs
    always_comb begin
        o_ready    = (r_state == gslr_pkg::ST_IDLE);
        s_accept   = o_ready && i_valid;
        s_out_free = !r_ovalid || i_ready;
        s_emit     = (r_state == gslr_pkg::ST_RUN) && s_out_free;
        s_done     = s_emit && (s_empty || s_lastw);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        unique case (r_state)
            gslr_pkg::ST_IDLE: begin
                n_phase = gslr_pkg::PH_COLS;
                if (s_accept) n_state = gslr_pkg::ST_MUL;
            end
            gslr_pkg::ST_MUL: begin
                unique case (r_phase)
                    gslr_pkg::PH_COLS:  n_phase = gslr_pkg::PH_ROWS;
                    gslr_pkg::PH_ROWS:  n_phase = gslr_pkg::PH_SC;
                    gslr_pkg::PH_SC:    n_phase = gslr_pkg::PH_SR;
                    gslr_pkg::PH_SR:    n_phase = gslr_pkg::PH_EC;
                    gslr_pkg::PH_EC:    n_phase = gslr_pkg::PH_ER;
                    gslr_pkg::PH_ER:    n_phase = gslr_pkg::PH_DRAIN;
                    default: begin
                        n_phase = gslr_pkg::PH_COLS;
                        n_state = gslr_pkg::ST_PREP;
                    end
                endcase
            end
            gslr_pkg::ST_PREP: n_state = gslr_pkg::ST_SETK;
            gslr_pkg::ST_SETK: n_state = gslr_pkg::ST_RUN;
            gslr_pkg::ST_RUN:  if (s_done) n_state = gslr_pkg::ST_IDLE;
            default:           n_state = gslr_pkg::ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gslr_pkg::ST_IDLE;
            r_phase  <= gslr_pkg::PH_COLS;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (s_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Setup datapath
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ymaj <= i_req_type;
            r_sc   <= i_start_col;
            r_sr   <= i_start_row;
            r_ec   <= i_end_col;
            r_er   <= i_end_row;
        end
        if (r_state == gslr_pkg::ST_MUL) begin
            r_prod <= s_mul;
            case (r_phase)
                gslr_pkg::PH_ROWS:  r_offx <= s_half;
                gslr_pkg::PH_SC:    r_offy <= s_half;
                gslr_pkg::PH_SR:    r_x    <= s_sum;
                gslr_pkg::PH_EC:    r_y    <= s_sum;
                gslr_pkg::PH_ER:    r_ex   <= s_sum;
                gslr_pkg::PH_DRAIN: r_ey   <= s_sum;
                default: ;
            endcase
        end
        // Assign major and minor axes
        if (r_state == gslr_pkg::ST_PREP) begin
            r_maj    <= r_ymaj ? r_y : r_x;
            r_mnr    <= r_ymaj ? r_x : r_y;
            r_endmaj <= r_ymaj ? r_ey : r_ex;
            r_dmaj   <= r_ymaj ? (r_ey - r_y) : (r_ex - r_x);
            r_dmnr   <= r_ymaj ? (r_ex - r_x) : (r_ey - r_y);
        end
        // Seed the decision term and its two increments
        if (r_state == gslr_pkg::ST_SETK) begin
            r_k     <= (gslr_pkg::t_k'(r_dmnr) <<< 1) - gslr_pkg::t_k'(r_dmaj);
            r_kpos  <= (gslr_pkg::t_k'(r_dmnr) - gslr_pkg::t_k'(r_dmaj)) <<< 1;
            r_kneg  <= gslr_pkg::t_k'(r_dmnr) <<< 1;
            r_count <= '0;
        end
        // Advance one pixel
        if (s_emit) begin
            r_k     <= s_knext;
            r_mnr   <= s_mnr_next;
            r_maj   <= r_maj + gslr_pkg::t_coord'(1);
            r_count <= r_count + 1'b1;
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_color <= r_ymaj ? gslr_pkg::COLOR_YMAJOR : gslr_pkg::COLOR_XMAJOR;
            if (s_empty) begin
                r_px   <= '0;
                r_py   <= '0;
                r_vis  <= 1'b0;
                r_cut  <= 1'b0;
                r_last <= 1'b1;
            end else begin
                r_px   <= s_vis ? s_px[gslr_pkg::PIX_W-1:0] : '0;
                r_py   <= s_vis ? s_py[gslr_pkg::PIX_W-1:0] : '0;
                r_vis  <= s_vis;
                r_cut  <= s_cut;
                r_last <= s_lastw;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_color;
    assign o_visible     = r_vis;
    assign o_cut_short   = r_cut;
    assign o_last        = r_last;

    `GSLR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_accept, !o_ready)
    `GSLR_ASSERT_NOW(a_idle_only_last_pending, i_clk, i_rst_n, o_ready && o_valid, o_last)
    `GSLR_ASSERT_NOW(a_cut_is_last, i_clk, i_rst_n, o_valid && o_cut_short, o_last)
    `GSLR_ASSERT_NOW(a_hidden_is_zero, i_clk, i_rst_n, o_valid && !o_visible,
        (o_pixel_x == '0) && (o_pixel_y == '0))

endmodule
